// File: rtl/core/bpp_pkg.sv
// Shared types, constants and fixed-point helpers for the Boris particle pusher.
// Q7.24 saturating arithmetic used by the pusher's arithmetic stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpp_pkg;

    // Q7.24 word
    typedef logic signed [31:0] t_q;

    localparam int CELL_COUNT_DEF = 4096;
    localparam int ROW_WORDS      = 18;
    localparam int FRAC_W         = 24;

    // Beat kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PUSH = 1'b1;

    // Interpolator word positions within a row
    localparam int W_EX       = 0;
    localparam int W_DEXDY    = 1;
    localparam int W_DEXDZ    = 2;
    localparam int W_D2EXDYDZ = 3;
    localparam int W_EY       = 4;
    localparam int W_DEYDZ    = 5;
    localparam int W_DEYDX    = 6;
    localparam int W_D2EYDZDX = 7;
    localparam int W_EZ       = 8;
    localparam int W_DEZDX    = 9;
    localparam int W_DEZDY    = 10;
    localparam int W_D2EZDXDY = 11;
    localparam int W_CBX      = 12;
    localparam int W_DCBXDX   = 13;
    localparam int W_CBY      = 14;
    localparam int W_DCBYDY   = 15;
    localparam int W_CBZ      = 16;
    localparam int W_DCBZDZ   = 17;

    // Q7.24 constants
    localparam t_q Q_ONE            = 32'sd16777216;
    localparam t_q Q_THIRD          = 32'sd5592405;
    localparam t_q Q_TWO_FIFTEENTHS = 32'sd2236962;
    localparam t_q Q_MAX            = 32'sh7FFF_FFFF;
    localparam t_q Q_MIN            = 32'sh8000_0000;
    localparam t_q CTS_RESET        = -32'sd163986;

    // Square root unit: radicand s * 2^24, root bits
    localparam int SQRT_W = 28;
    localparam int RAD_W  = 56;

    // Divider: quotient bits, remainder bits, compare width
    localparam int DIV_Q_W = 32;
    localparam int DIV_R_W = 56;
    localparam int DIV_C_W = 63;

    // One interpolator row
    typedef logic [ROW_WORDS-1:0][31:0] t_row;

    typedef struct packed {
        logic       kind;
        logic [11:0] cell_req;
        logic [4:0] word_select;
        t_q         word_value;
        t_q         offset_x;
        t_q         offset_y;
        t_q         offset_z;
        t_q         momentum_x_in;
        t_q         momentum_y_in;
        t_q         momentum_z_in;
    } t_in_beat;

    typedef struct packed {
        t_q momentum_x_out;
        t_q momentum_y_out;
        t_q momentum_z_out;
    } t_out_beat;

    // Values that ride alongside the sqrt and divider units
    typedef struct packed {
        t_q ux;
        t_q uy;
        t_q uz;
        t_q hax;
        t_q hay;
        t_q haz;
        t_q cbx;
        t_q cby;
        t_q cbz;
        t_q aux;
    } t_carry;

    // Clamp to the Q7.24 range
    function automatic t_q q_sat(input logic signed [63:0] v);
        t_q r;
        if (v > 64'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < 64'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_q q_add(input t_q a, input t_q b);
        return q_sat(64'(a) + 64'(b));
    endfunction

    function automatic t_q q_sub(input t_q a, input t_q b);
        return q_sat(64'(a) - 64'(b));
    endfunction

    // Product rounded half up, floor shift by the fraction width
    function automatic t_q q_mul(input t_q a, input t_q b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd8388608;
        return q_sat(p >>> FRAC_W);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/boris_particle_push.sv
// Boris particle pusher: one push or load beat accepted per clock while the output is not
// held. A load beat writes one interpolator word of one cell in the same edge that accepts
// it and returns nothing. A push beat runs through a fixed 112-stage pipeline (field
// interpolation, half E kick, a 28-stage square root, two 33-stage dividers, rotation,
// second kick) that ends in the output register.
// Throughput is one beat per cycle; a stall on the output freezes the whole pipeline.
// The table has no reset: a push must only read words that were loaded.
// Uses bpp_pkg, bpp_field_table, bpp_sqrt_pipe, bpp_div_pipe.
`timescale 1ns / 1ps
`default_nettype none

module boris_particle_push import bpp_pkg::*; #(
    parameter int CELL_COUNT = CELL_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  t_q        i_cfg_data,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    logic adv;
    logic accept;
    t_q   r_cts;

    // pipeline moves whenever the output register is free
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;
    assign accept  = i_valid && adv;

    // charge/time scale register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cts <= CTS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cts <= i_cfg_data;
        end
    end

    // cell decode
    logic [AW+11:0] cell_ext;
    logic [AW-1:0]  cell_addr;
    logic           cell_ok;
    logic           wr_en;
    t_row           row;
    assign cell_ext  = (AW+12)'(i_data.cell_req);
    assign cell_addr = cell_ext[AW-1:0];
    assign cell_ok   = cell_ext < (AW+12)'(CELL_COUNT);
    assign wr_en     = accept && (i_data.kind == KIND_LOAD) && cell_ok
                       && (i_data.word_select < 5'(ROW_WORDS));

    bpp_field_table #(
        .CELL_COUNT(CELL_COUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (adv),
        .i_addr    (cell_addr),
        .i_wr_en   (wr_en),
        .i_wr_sel  (i_data.word_select),
        .i_wr_data (i_data.word_value),
        .o_row     (row)
    );

    // stage 1: beat captured alongside the row read
    logic r1_valid, r1_in_range;
    t_q   r1_dx, r1_dy, r1_dz, r1_ux, r1_uy, r1_uz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= accept && (i_data.kind == KIND_PUSH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_in_range <= cell_ok;
            r1_dx <= i_data.offset_x;
            r1_dy <= i_data.offset_y;
            r1_dz <= i_data.offset_z;
            r1_ux <= i_data.momentum_x_in;
            r1_uy <= i_data.momentum_y_in;
            r1_uz <= i_data.momentum_z_in;
        end
    end

    // stage 2: first-order products; cells out of range read as zero
    t_q w [ROW_WORDS];
    always_comb begin
        for (int k = 0; k < ROW_WORDS; k++) begin
            w[k] = r1_in_range ? t_q'(row[k]) : '0;
        end
    end

    logic r2_valid;
    t_q   r2_p1, r2_p3, r2_p5, r2_p7, r2_p9, r2_p11, r2_p13, r2_p15, r2_p17;
    t_q   r2_ex, r2_dexdz, r2_ey, r2_deydx, r2_ez, r2_dezdy, r2_cbx, r2_cby, r2_cbz;
    t_q   r2_dx, r2_dy, r2_dz, r2_ux, r2_uy, r2_uz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_p1  <= q_mul(r1_dy, w[W_DEXDY]);
            r2_p3  <= q_mul(r1_dy, w[W_D2EXDYDZ]);
            r2_p5  <= q_mul(r1_dz, w[W_DEYDZ]);
            r2_p7  <= q_mul(r1_dz, w[W_D2EYDZDX]);
            r2_p9  <= q_mul(r1_dx, w[W_DEZDX]);
            r2_p11 <= q_mul(r1_dx, w[W_D2EZDXDY]);
            r2_p13 <= q_mul(r1_dx, w[W_DCBXDX]);
            r2_p15 <= q_mul(r1_dy, w[W_DCBYDY]);
            r2_p17 <= q_mul(r1_dz, w[W_DCBZDZ]);
            r2_ex    <= w[W_EX];
            r2_dexdz <= w[W_DEXDZ];
            r2_ey    <= w[W_EY];
            r2_deydx <= w[W_DEYDX];
            r2_ez    <= w[W_EZ];
            r2_dezdy <= w[W_DEZDY];
            r2_cbx   <= w[W_CBX];
            r2_cby   <= w[W_CBY];
            r2_cbz   <= w[W_CBZ];
            r2_dx <= r1_dx; r2_dy <= r1_dy; r2_dz <= r1_dz;
            r2_ux <= r1_ux; r2_uy <= r1_uy; r2_uz <= r1_uz;
        end
    end

    // stage 3: cross terms, linear sums, B at the particle
    logic r3_valid;
    t_q   r3_mx, r3_my, r3_mz, r3_tx, r3_ty, r3_tz, r3_cbx, r3_cby, r3_cbz;
    t_q   r3_ux, r3_uy, r3_uz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (adv) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_mx  <= q_mul(r2_dz, q_add(r2_dexdz, r2_p3));
            r3_my  <= q_mul(r2_dx, q_add(r2_deydx, r2_p7));
            r3_mz  <= q_mul(r2_dy, q_add(r2_dezdy, r2_p11));
            r3_tx  <= q_add(r2_ex, r2_p1);
            r3_ty  <= q_add(r2_ey, r2_p5);
            r3_tz  <= q_add(r2_ez, r2_p9);
            r3_cbx <= q_add(r2_cbx, r2_p13);
            r3_cby <= q_add(r2_cby, r2_p15);
            r3_cbz <= q_add(r2_cbz, r2_p17);
            r3_ux <= r2_ux; r3_uy <= r2_uy; r3_uz <= r2_uz;
        end
    end

    // stage 4: scaled half E kick
    logic r4_valid;
    t_q   r4_hax, r4_hay, r4_haz, r4_cbx, r4_cby, r4_cbz, r4_ux, r4_uy, r4_uz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (adv) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_hax <= q_mul(r_cts, q_add(r3_tx, r3_mx));
            r4_hay <= q_mul(r_cts, q_add(r3_ty, r3_my));
            r4_haz <= q_mul(r_cts, q_add(r3_tz, r3_mz));
            r4_cbx <= r3_cbx; r4_cby <= r3_cby; r4_cbz <= r3_cbz;
            r4_ux  <= r3_ux;  r4_uy  <= r3_uy;  r4_uz  <= r3_uz;
        end
    end

    // stage 5: kicked momentum and squares
    logic r5_valid;
    t_q   r5_ux, r5_uy, r5_uz, r5_sqx, r5_sqy, r5_sqz, r5_bsx, r5_bsy, r5_bsz;
    t_q   r5_hax, r5_hay, r5_haz, r5_cbx, r5_cby, r5_cbz;
    t_q   kux, kuy, kuz;

    assign kux = q_add(r4_ux, r4_hax);
    assign kuy = q_add(r4_uy, r4_hay);
    assign kuz = q_add(r4_uz, r4_haz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (adv) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_ux  <= kux; r5_uy <= kuy; r5_uz <= kuz;
            r5_sqx <= q_mul(kux, kux);
            r5_sqy <= q_mul(kuy, kuy);
            r5_sqz <= q_mul(kuz, kuz);
            r5_bsx <= q_mul(r4_cbx, r4_cbx);
            r5_bsy <= q_mul(r4_cby, r4_cby);
            r5_bsz <= q_mul(r4_cbz, r4_cbz);
            r5_hax <= r4_hax; r5_hay <= r4_hay; r5_haz <= r4_haz;
            r5_cbx <= r4_cbx; r5_cby <= r4_cby; r5_cbz <= r4_cbz;
        end
    end

    // stage 6: 1 + |u|^2 and |B|^2
    logic   r6_valid;
    t_q     r6_s;
    t_carry r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (adv) begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_s        <= q_add(Q_ONE, q_add(r5_sqx, q_add(r5_sqy, r5_sqz)));
            r6_side.ux  <= r5_ux;  r6_side.uy  <= r5_uy;  r6_side.uz  <= r5_uz;
            r6_side.hax <= r5_hax; r6_side.hay <= r5_hay; r6_side.haz <= r5_haz;
            r6_side.cbx <= r5_cbx; r6_side.cby <= r5_cby; r6_side.cbz <= r5_cbz;
            r6_side.aux <= q_add(r5_bsx, q_add(r5_bsy, r5_bsz));
        end
    end

    // gamma * 2^24 by square root
    logic              sq_valid;
    logic [SQRT_W-1:0] sq_root;
    t_carry            sq_side;

    bpp_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r6_valid),
        .i_s     (r6_s),
        .i_side  (r6_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // v0 = q / gamma
    logic   d1_valid;
    t_q     d1_quo;
    t_carry d1_side;

    bpp_div_pipe u_div_gamma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (sq_valid),
        .i_num   (r_cts),
        .i_den   (32'(sq_root)),
        .i_side  (sq_side),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // stages 7..13: Taylor-corrected tangent and the rotation denominator
    logic   r7_valid, r8_valid, r9_valid, r10_valid, r11_valid, r12_valid, r13_valid;
    t_q     r7_v0sq, r7_v0, r8_v2, r8_v0, r9_t1, r9_v2, r9_v0, r10_t2, r10_v0;
    t_q     r11_v3, r12_v3sq, r12_v3, r13_t3, r13_v3;
    t_carry r7_side, r8_side, r9_side, r10_side, r11_side, r12_side, r13_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid  <= 1'b0; r8_valid  <= 1'b0; r9_valid  <= 1'b0;
            r10_valid <= 1'b0; r11_valid <= 1'b0; r12_valid <= 1'b0;
            r13_valid <= 1'b0;
        end else if (adv) begin
            r7_valid  <= d1_valid;  r8_valid  <= r7_valid;  r9_valid  <= r8_valid;
            r10_valid <= r9_valid;  r11_valid <= r10_valid; r12_valid <= r11_valid;
            r13_valid <= r12_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_v0sq  <= q_mul(d1_quo, d1_quo);
            r7_v0    <= d1_quo;
            r7_side  <= d1_side;
            r8_v2    <= q_mul(r7_v0sq, r7_side.aux);
            r8_v0    <= r7_v0;
            r8_side  <= r7_side;
            r9_t1    <= q_mul(r8_v2, Q_TWO_FIFTEENTHS);
            r9_v2    <= r8_v2;
            r9_v0    <= r8_v0;
            r9_side  <= r8_side;
            r10_t2   <= q_mul(r9_v2, q_add(Q_THIRD, r9_t1));
            r10_v0   <= r9_v0;
            r10_side <= r9_side;
            r11_v3   <= q_mul(r10_v0, q_add(Q_ONE, r10_t2));
            r11_side <= r10_side;
            r12_v3sq <= q_mul(r11_v3, r11_v3);
            r12_v3   <= r11_v3;
            r12_side <= r11_side;
            r13_t3   <= q_mul(r12_side.aux, r12_v3sq);
            r13_v3   <= r12_v3;
            r13_side <= r12_side;
        end
    end

    // v4 = v3 / (1 + |B|^2 v3^2); aux now carries v3
    t_q     den2;
    t_carry d2_side_in;
    logic   d2_valid;
    t_q     d2_quo;
    t_carry d2_side;

    assign den2 = q_add(Q_ONE, r13_t3);
    always_comb begin
        d2_side_in     = r13_side;
        d2_side_in.aux = r13_v3;
    end

    bpp_div_pipe u_div_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r13_valid),
        .i_num   (r13_v3),
        .i_den   (den2),
        .i_side  (d2_side_in),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // stage 14: doubled v4 and u x B products
    logic   r14_valid;
    t_q     r14_v4, r14_pyz, r14_pzy, r14_pzx, r14_pxz, r14_pxy, r14_pyx;
    t_carry r14_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r14_valid <= 1'b0;
        end else if (adv) begin
            r14_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r14_v4   <= q_add(d2_quo, d2_quo);
            r14_pyz  <= q_mul(d2_side.uy, d2_side.cbz);
            r14_pzy  <= q_mul(d2_side.uz, d2_side.cby);
            r14_pzx  <= q_mul(d2_side.uz, d2_side.cbx);
            r14_pxz  <= q_mul(d2_side.ux, d2_side.cbz);
            r14_pxy  <= q_mul(d2_side.ux, d2_side.cby);
            r14_pyx  <= q_mul(d2_side.uy, d2_side.cbx);
            r14_side <= d2_side;
        end
    end

    // stage 15: first half of the rotation, scaled by v3
    logic   r15_valid;
    t_q     r15_cx, r15_cy, r15_cz, r15_v4;
    t_carry r15_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r15_valid <= 1'b0;
        end else if (adv) begin
            r15_valid <= r14_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r15_cx   <= q_mul(r14_side.aux, q_sub(r14_pyz, r14_pzy));
            r15_cy   <= q_mul(r14_side.aux, q_sub(r14_pzx, r14_pxz));
            r15_cz   <= q_mul(r14_side.aux, q_sub(r14_pxy, r14_pyx));
            r15_v4   <= r14_v4;
            r15_side <= r14_side;
        end
    end

    // stage 16: u' = u + v3 (u x B), then u' x B products
    logic   r16_valid;
    t_q     r16_pa, r16_pb, r16_pc, r16_pd, r16_pe, r16_pf, r16_v4;
    t_carry r16_side;
    t_q     vx, vy, vz;

    assign vx = q_add(r15_side.ux, r15_cx);
    assign vy = q_add(r15_side.uy, r15_cy);
    assign vz = q_add(r15_side.uz, r15_cz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r16_valid <= 1'b0;
        end else if (adv) begin
            r16_valid <= r15_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r16_pa   <= q_mul(vy, r15_side.cbz);
            r16_pb   <= q_mul(vz, r15_side.cby);
            r16_pc   <= q_mul(vz, r15_side.cbx);
            r16_pd   <= q_mul(vx, r15_side.cbz);
            r16_pe   <= q_mul(vx, r15_side.cby);
            r16_pf   <= q_mul(vy, r15_side.cbx);
            r16_v4   <= r15_v4;
            r16_side <= r15_side;
        end
    end

    // stage 17: second half of the rotation, scaled by v4
    logic   r17_valid;
    t_q     r17_dx, r17_dy, r17_dz;
    t_carry r17_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r17_valid <= 1'b0;
        end else if (adv) begin
            r17_valid <= r16_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r17_dx   <= q_mul(r16_v4, q_sub(r16_pa, r16_pb));
            r17_dy   <= q_mul(r16_v4, q_sub(r16_pc, r16_pd));
            r17_dz   <= q_mul(r16_v4, q_sub(r16_pe, r16_pf));
            r17_side <= r16_side;
        end
    end

    // stage 18: second half E kick into the output register
    logic      r_out_valid;
    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r17_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.momentum_x_out <= q_add(q_add(r17_side.ux, r17_dx), r17_side.hax);
            r_out.momentum_y_out <= q_add(q_add(r17_side.uy, r17_dy), r17_side.hay);
            r_out.momentum_z_out <= q_add(q_add(r17_side.uz, r17_dz), r17_side.haz);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // a load beat never enters the arithmetic pipeline
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_data.kind == KIND_LOAD)) |=> !r1_valid)
        else $error("load beat entered the push pipeline");

    // gamma is at least one, so the first divisor is never below 1.0
    a_gamma_ge_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_valid |-> (sq_root[SQRT_W-1:FRAC_W] != '0))
        else $error("square root below 1.0");

    // rotation denominator is at least 1.0
    a_den_ge_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r13_valid |-> (den2 >= Q_ONE))
        else $error("rotation divisor below 1.0");

    // a held output freezes the pipeline front
    a_hold_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(r1_valid) && $stable(r13_valid)))
        else $error("pipeline moved while output held");

endmodule

`default_nettype wire

// File: rtl/core/bpp_field_table.sv
// Per-cell interpolator store: one bank per row word, written a word at a time,
// read a full row per cycle while i_rd_en is high, with registered data. Uses bpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpp_field_table import bpp_pkg::*; #(
    parameter int CELL_COUNT = CELL_COUNT_DEF,
    localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_addr,
    input  logic                  i_wr_en,
    input  logic [4:0]            i_wr_sel,
    input  logic [31:0]           i_wr_data,
    output t_row                  o_row
);

    t_row r_row;

    // one bank per word so a load touches a single word of the row
    for (genvar k = 0; k < ROW_WORDS; k++) begin : g_bank
        logic [31:0] mem [CELL_COUNT];

        always_ff @(posedge i_clk) begin
            if (i_wr_en && (i_wr_sel == 5'(k))) begin
                mem[i_addr] <= i_wr_data;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_rd_en) begin
                r_row[k] <= mem[i_addr];
            end
        end
    end

    assign o_row = r_row;

endmodule

`default_nettype wire

// File: rtl/core/bpp_sqrt_pipe.sv
// Pipelined integer square root of s * 2^24, one root bit per stage,
// with carried side values. Uses bpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpp_sqrt_pipe import bpp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_q                 i_s,
    input  t_carry             i_side,
    output logic               o_valid,
    output logic [SQRT_W-1:0]  o_root,
    output t_carry             o_side
);

    logic              r_valid [SQRT_W];
    logic [RAD_W-1:0]  r_rem   [SQRT_W];
    logic [SQRT_W-1:0] r_root  [SQRT_W];
    t_carry            r_side  [SQRT_W];

    for (genvar k = 0; k < SQRT_W; k++) begin : g_stage
        localparam int B = SQRT_W - 1 - k;

        logic              v_in;
        logic [RAD_W-1:0]  rem_in;
        logic [SQRT_W-1:0] root_in;
        t_carry            side_in;
        logic [RAD_W:0]    trial;
        logic [RAD_W:0]    diff;
        logic              take;
        logic [RAD_W-1:0]  n_rem;
        logic [SQRT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = {i_s, {FRAC_W{1'b0}}};
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
        assign trial  = ((RAD_W+1)'(root_in) << (B + 1)) + ((RAD_W+1)'(1) << (2 * B));
        assign diff   = {1'b0, rem_in} - trial;
        assign take   = ({1'b0, rem_in} >= trial);
        assign n_rem  = take ? diff[RAD_W-1:0] : rem_in;
        assign n_root = take ? (root_in | (SQRT_W'(1) << B)) : root_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[SQRT_W-1];
    assign o_root  = r_root[SQRT_W-1];
    assign o_side  = r_side[SQRT_W-1];

endmodule

`default_nettype wire

// File: rtl/core/bpp_div_pipe.sv
// Pipelined signed Q7.24 divider (n * 2^24) / d, d positive, truncating and
// saturating; one quotient bit per stage plus a sign stage. Uses bpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpp_div_pipe import bpp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_q      i_num,
    input  logic [31:0] i_den,
    input  t_carry  i_side,
    output logic    o_valid,
    output t_q      o_quo,
    output t_carry  o_side
);

    logic               r_valid [DIV_Q_W];
    logic [DIV_R_W-1:0] r_rem   [DIV_Q_W];
    logic [DIV_Q_W-1:0] r_quo   [DIV_Q_W];
    logic [31:0]        r_den   [DIV_Q_W];
    logic               r_neg   [DIV_Q_W];
    t_carry             r_side  [DIV_Q_W];

    logic   r_out_valid;
    t_q     r_out;
    t_carry r_out_side;

    // magnitude of the numerator, at most 2^31
    logic [32:0] num_ext;
    logic [32:0] num_mag;
    assign num_ext = {i_num[31], i_num};
    assign num_mag = i_num[31] ? (~num_ext + 33'd1) : num_ext;

    for (genvar k = 0; k < DIV_Q_W; k++) begin : g_stage
        localparam int B = DIV_Q_W - 1 - k;

        logic               v_in;
        logic [DIV_R_W-1:0] rem_in;
        logic [DIV_Q_W-1:0] quo_in;
        logic [31:0]        den_in;
        logic               neg_in;
        t_carry             side_in;
        logic [DIV_C_W-1:0] shifted;
        logic [DIV_C_W-1:0] diff;
        logic               take;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = {num_mag[31:0], {FRAC_W{1'b0}}};
            assign quo_in  = '0;
            assign den_in  = i_den;
            assign neg_in  = i_num[31];
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[k-1];
            assign rem_in  = r_rem[k-1];
            assign quo_in  = r_quo[k-1];
            assign den_in  = r_den[k-1];
            assign neg_in  = r_neg[k-1];
            assign side_in = r_side[k-1];
        end

        assign shifted = DIV_C_W'(den_in) << B;
        assign diff    = DIV_C_W'(rem_in) - shifted;
        assign take    = (DIV_C_W'(rem_in) >= shifted);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? diff[DIV_R_W-1:0] : rem_in;
                r_quo[k]  <= take ? (quo_in | (DIV_Q_W'(1) << B)) : quo_in;
                r_den[k]  <= den_in;
                r_neg[k]  <= neg_in;
                r_side[k] <= side_in;
            end
        end
    end

    // restore the sign, clamp
    logic signed [33:0] quo_signed;
    assign quo_signed = r_neg[DIV_Q_W-1] ? -$signed({2'b00, r_quo[DIV_Q_W-1]})
                                         :  $signed({2'b00, r_quo[DIV_Q_W-1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_valid[DIV_Q_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out      <= q_sat(64'(quo_signed));
            r_out_side <= r_side[DIV_Q_W-1];
        end
    end

    assign o_valid = r_out_valid;
    assign o_quo   = r_out;
    assign o_side  = r_out_side;

endmodule

`default_nettype wire
